// ----- rtl/core/scl_pkg.sv -----
// Shared types and constants for the source comment lexer.
// No dependencies; every other file in rtl/core imports this package.
package scl_pkg;

  // Result word kinds
  typedef enum logic [2:0] {
    K_TEXT   = 3'd0,
    K_LSTART = 3'd1,
    K_LEND   = 3'd2,
    K_BSTART = 3'd3,
    K_BEND   = 3'd4,
    K_NL     = 3'd5
  } kind_t;

  // Comment styles held in the style register
  localparam logic [1:0] STYLE_SLASH = 2'd1;
  localparam logic [1:0] STYLE_NEST  = 2'd2;
  localparam logic [1:0] STYLE_HASH  = 2'd3;
  localparam logic [1:0] STYLE_RESET = STYLE_SLASH;

  // Delimiter and quote characters
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;

  // Block depth counter width
  localparam int DEPTH_BITS_DEF = 8;

  // Register file: one register, word index taken from paddr[2]
  localparam int   PADDR_W   = 3;
  localparam logic REG_STYLE = 1'b0;

  // Result queue
  localparam int RQ_DEPTH = 4;
  localparam int RQ_AW    = 2;

  // One result word
  typedef struct packed {
    kind_t      kind;
    logic [7:0] text_byte;
  } res_t;

  // Results of one item, handed from the step logic to the queue
  typedef struct packed {
    logic [1:0] count;
    res_t       r0;
    res_t       r1;
  } step_out_t;

endpackage

// ----- rtl/core/scl_in_if.sv -----
// Input channel of the source comment lexer: one source byte or line end per word.
// Depends on scl_pkg.
interface scl_in_if;
  import scl_pkg::*;

  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       line_end;
  logic       file_start;

  modport source (output valid, char_byte, line_end, file_start, input ready);
  modport sink   (input valid, char_byte, line_end, file_start, output ready);
endinterface

// ----- rtl/core/scl_out_if.sv -----
// Output channel of the source comment lexer: one text byte or comment marker per word.
// Depends on scl_pkg for the kind type.
interface scl_out_if;
  import scl_pkg::*;

  logic       valid;
  logic       ready;
  kind_t      kind;
  logic [7:0] text_byte;
  logic       last;

  modport source (output valid, kind, text_byte, last, input ready);
  modport sink   (input valid, kind, text_byte, last, output ready);
endinterface

// ----- rtl/core/source_comment_lexer.sv -----
// A result word is written to the queue as its source word is taken and shows on tokens
// in the next cycle if the queue was empty. One source word is taken per cycle while
// chars.ready is high; it drops while fewer than two of the four result queue entries
// are free. Scanner state is decoded in one combinational pass. Reset (rst, synchronous):
// scanner state and queue cleared, style 1.
// Depends on scl_pkg, scl_in_if, scl_out_if and scl_step.
module source_comment_lexer #(
  parameter int DEPTH_BITS = scl_pkg::DEPTH_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  scl_in_if.sink                      chars,
  scl_out_if.source                   tokens,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [scl_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import scl_pkg::*;

  logic [1:0]       style;
  logic             cfg_wr;
  logic             fire;
  logic             pop;
  step_out_t        res;
  logic [1:0]       wr_cnt;

  kind_t            q_kind [RQ_DEPTH];
  logic [7:0]       q_byte [RQ_DEPTH];
  logic             q_last [RQ_DEPTH];
  logic [RQ_AW-1:0] head;
  logic [RQ_AW-1:0] tail;
  logic [RQ_AW:0]   count;

  // Configuration register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_STYLE);
  assign prdata = (paddr[2] == REG_STYLE) ? {30'b0, style} : 32'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      style <= STYLE_RESET;
    end else if (cfg_wr) begin
      style <= pwdata[1:0];
    end
  end

  // Accept while two queue entries are free
  assign chars.ready = (count <= (RQ_AW+1)'(RQ_DEPTH - 2));
  assign fire        = chars.valid && chars.ready;
  assign pop         = tokens.valid && tokens.ready;
  assign wr_cnt      = fire ? res.count : 2'd0;

  scl_step #(
    .DEPTH_BITS (DEPTH_BITS)
  ) u_step (
    .clk        (clk),
    .rst        (rst),
    .fire       (fire),
    .char_byte  (chars.char_byte),
    .line_end   (chars.line_end),
    .file_start (chars.file_start),
    .style      (style),
    .res        (res)
  );

  // Queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      tail  <= tail + RQ_AW'(wr_cnt);
      head  <= head + RQ_AW'(pop);
      count <= count + (RQ_AW+1)'(wr_cnt) - (RQ_AW+1)'(pop);
    end
  end

  // Queue storage: write one or two words per item
  always_ff @(posedge clk) begin
    if (wr_cnt != 2'd0) begin
      q_kind[tail] <= res.r0.kind;
      q_byte[tail] <= res.r0.text_byte;
      q_last[tail] <= (wr_cnt == 2'd1);
    end
    if (wr_cnt == 2'd2) begin
      q_kind[tail + 1'b1] <= res.r1.kind;
      q_byte[tail + 1'b1] <= res.r1.text_byte;
      q_last[tail + 1'b1] <= 1'b1;
    end
  end

  // Present the head word
  assign tokens.valid     = (count != '0);
  assign tokens.kind      = q_kind[head];
  assign tokens.text_byte = q_byte[head];
  assign tokens.last      = q_last[head];

endmodule

// ----- rtl/core/scl_step.sv -----
// Scanner state and the single-pass next-state logic for one input word.
// Depends on scl_pkg; instantiated by source_comment_lexer.
module scl_step #(
  parameter int DEPTH_BITS = scl_pkg::DEPTH_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                fire,
  input  logic [7:0]          char_byte,
  input  logic                line_end,
  input  logic                file_start,
  input  logic [1:0]          style,
  output scl_pkg::step_out_t  res
);
  import scl_pkg::*;

  // Scanner state
  logic [7:0]            held_byte;
  logic                  held_valid;
  logic [DEPTH_BITS-1:0] block_level;
  logic [7:0]            quote_open;
  logic                  escape_pending;
  logic                  in_line_comment;

  logic [7:0]            held_byte_next;
  logic                  held_valid_next;
  logic [DEPTH_BITS-1:0] block_level_next;
  logic [7:0]            quote_open_next;
  logic                  escape_pending_next;
  logic                  in_line_comment_next;

  logic [DEPTH_BITS-1:0] lvl_cur;
  logic                  slash;

  // Fresh-byte decode
  logic                  f_emit;
  logic                  f_hold;
  kind_t                 f_kind;
  logic [7:0]            f_byte;
  logic                  f_il;
  logic [7:0]            f_q;
  logic                  f_esc;

  // Held-pair decode
  logic                  p_match;
  kind_t                 p_kind;
  logic [DEPTH_BITS-1:0] p_lvl;
  logic                  p_il;

  kind_t                 eol_kind;

  assign lvl_cur  = file_start ? '0 : block_level;
  assign slash    = (style == STYLE_SLASH) || (style == STYLE_NEST);
  assign eol_kind = in_line_comment ? K_LEND : K_NL;

  // Decode a byte with nothing held
  always_comb begin
    f_emit = 1'b1;
    f_hold = 1'b0;
    f_kind = K_TEXT;
    f_il   = in_line_comment;
    f_q    = quote_open;
    f_esc  = escape_pending;
    if (in_line_comment) begin
      f_emit = 1'b1;
    end else if (lvl_cur != '0) begin
      if (char_byte == CH_STAR || (style == STYLE_NEST && char_byte == CH_SLASH)) begin
        f_emit = 1'b0;
        f_hold = 1'b1;
      end
    end else if (quote_open != 8'h00) begin
      if (escape_pending) begin
        f_esc = 1'b0;
      end else if (char_byte == CH_BSLASH) begin
        f_esc = 1'b1;
      end else if (char_byte == quote_open) begin
        f_q = 8'h00;
      end
    end else if (char_byte == CH_SQUOTE || char_byte == CH_DQUOTE) begin
      f_q = char_byte;
    end else if (style == STYLE_HASH && char_byte == CH_HASH) begin
      f_il   = 1'b1;
      f_kind = K_LSTART;
    end else if (slash && char_byte == CH_SLASH) begin
      f_emit = 1'b0;
      f_hold = 1'b1;
    end
    f_byte = (f_kind == K_TEXT) ? char_byte : 8'h00;
  end

  // Decide whether the held byte and the new byte form a delimiter
  always_comb begin
    p_match = 1'b0;
    p_kind  = K_BSTART;
    p_lvl   = lvl_cur;
    p_il    = in_line_comment;
    if (lvl_cur != '0) begin
      if (style == STYLE_NEST && held_byte == CH_SLASH && char_byte == CH_STAR) begin
        p_match = 1'b1;
        // saturate at the top of the counter
        if (!(&lvl_cur)) begin
          p_lvl = lvl_cur + 1'b1;
        end
      end else if (held_byte == CH_STAR && char_byte == CH_SLASH) begin
        p_match = 1'b1;
        p_kind  = K_BEND;
        p_lvl   = lvl_cur - 1'b1;
      end
    end else if (!in_line_comment && quote_open == 8'h00 && slash && held_byte == CH_SLASH) begin
      if (char_byte == CH_SLASH) begin
        p_match = 1'b1;
        p_kind  = K_LSTART;
        p_il    = 1'b1;
      end else if (char_byte == CH_STAR) begin
        p_match = 1'b1;
        p_lvl   = DEPTH_BITS'(1);
      end
    end
  end

  // Combine: line end, held pair, held byte then fresh byte, or fresh byte
  always_comb begin
    res                  = '0;
    res.r0.kind          = K_TEXT;
    res.r1.kind          = K_TEXT;
    held_byte_next       = held_byte;
    held_valid_next      = held_valid;
    block_level_next     = lvl_cur;
    quote_open_next      = quote_open;
    escape_pending_next  = escape_pending;
    in_line_comment_next = in_line_comment;
    if (line_end) begin
      if (held_valid) begin
        res.r0 = '{kind: K_TEXT, text_byte: held_byte};
        res.r1 = '{kind: eol_kind, text_byte: 8'h00};
        res.count = 2'd2;
      end else begin
        res.r0 = '{kind: eol_kind, text_byte: 8'h00};
        res.count = 2'd1;
      end
      held_valid_next      = 1'b0;
      held_byte_next       = 8'h00;
      quote_open_next      = 8'h00;
      escape_pending_next  = 1'b0;
      in_line_comment_next = 1'b0;
    end else if (held_valid && p_match) begin
      res.r0               = '{kind: p_kind, text_byte: 8'h00};
      res.count            = 2'd1;
      held_valid_next      = 1'b0;
      held_byte_next       = 8'h00;
      block_level_next     = p_lvl;
      in_line_comment_next = p_il;
    end else if (held_valid) begin
      // held byte falls out as text, then the new byte is decoded on its own
      res.r0               = '{kind: K_TEXT, text_byte: held_byte};
      res.r1               = '{kind: f_kind, text_byte: f_byte};
      res.count            = f_emit ? 2'd2 : 2'd1;
      held_valid_next      = f_hold;
      held_byte_next       = f_hold ? char_byte : 8'h00;
      quote_open_next      = f_q;
      escape_pending_next  = f_esc;
      in_line_comment_next = f_il;
    end else begin
      res.r0               = '{kind: f_kind, text_byte: f_byte};
      res.count            = f_emit ? 2'd1 : 2'd0;
      held_valid_next      = f_hold;
      held_byte_next       = f_hold ? char_byte : 8'h00;
      quote_open_next      = f_q;
      escape_pending_next  = f_esc;
      in_line_comment_next = f_il;
    end
  end

  // Advance state on each accepted word
  always_ff @(posedge clk) begin
    if (rst) begin
      held_byte       <= 8'h00;
      held_valid      <= 1'b0;
      block_level     <= '0;
      quote_open      <= 8'h00;
      escape_pending  <= 1'b0;
      in_line_comment <= 1'b0;
    end else if (fire) begin
      held_byte       <= held_byte_next;
      held_valid      <= held_valid_next;
      block_level     <= block_level_next;
      quote_open      <= quote_open_next;
      escape_pending  <= escape_pending_next;
      in_line_comment <= in_line_comment_next;
    end
  end

endmodule

// ----- rtl/core/scl_chk.sv -----
// Port-level checks for source_comment_lexer, bound to every instance of it.
// Depends on scl_pkg.
module scl_chk (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       in_line_end,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] out_kind,
  input logic [7:0] out_text,
  input logic       out_last
);
  import scl_pkg::*;

  // Reset empties the result queue
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result word present after reset");

  // Markers carry no byte
  a_marker_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_kind != K_TEXT) |-> (out_text == 8'h00))
    else $error("marker word with nonzero byte");

  // A line end always yields a word; with the queue empty it shows next cycle
  a_eol_result: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && in_line_end && !out_valid) |=> out_valid)
    else $error("line end produced no result word");

  // A stalled word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_kind) && $stable(out_text) && $stable(out_last)))
    else $error("stalled result word changed");

endmodule

bind source_comment_lexer scl_chk u_scl_chk (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (chars.valid),
  .in_ready    (chars.ready),
  .in_line_end (chars.line_end),
  .out_valid   (tokens.valid),
  .out_ready   (tokens.ready),
  .out_kind    (tokens.kind),
  .out_text    (tokens.text_byte),
  .out_last    (tokens.last)
);

// ----- test/source_comment_lexer_tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for source_comment_lexer: directed table, then random source text.
// Depends on scl_pkg, scl_in_if, scl_out_if and the lexer RTL.
module source_comment_lexer_tb;
  import scl_pkg::*;

  // Narrow depth counter so saturation is reached in a short run
  localparam int DEPTH_BITS   = 4;
  localparam int CLK_HALF     = 6;
  localparam int RESET_CYCLES = 10;
  localparam int SETTLE       = 4;
  localparam int TAIL         = 20;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int PHASE_ITEMS  = 62;
  localparam int NUM_PHASES   = 6;
  localparam int PREDICTED    = -1;
  localparam int NEST_OPENS   = 20;
  localparam logic [1:0] STYLE_NONE = 2'd0;
  localparam logic [DEPTH_BITS-1:0] LEVEL_MAX = '1;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] text_byte;
    logic       last;
  } tok_t;

  typedef struct {
    logic [7:0] c;
    logic       le;
    logic       fs;
    int         n_exp;
    kind_t      k0;
    logic [7:0] b0;
    kind_t      k1;
    logic [7:0] b1;
  } dir_row_t;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  scl_in_if  chars_if ();
  scl_out_if tokens_if ();

  source_comment_lexer #(
    .DEPTH_BITS (DEPTH_BITS)
  ) u_top (
    .clk     (clk),
    .rst     (rst),
    .chars   (chars_if),
    .tokens  (tokens_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Scanner copy kept by the testbench
  logic [1:0]            style_reg;
  logic [7:0]            pend_byte;
  logic                  pend_valid;
  logic [DEPTH_BITS-1:0] nest_level;
  logic [7:0]            quote_char;
  logic                  esc_pending;
  logic                  in_line_cmt;

  tok_t step_toks [$];
  tok_t typed_toks [$];
  tok_t token_q [$];

  int err_cnt     = 0;
  int cycle_cnt   = 0;
  int src_idle_pct  = 0;
  int sink_idle_pct = 0;

  // Expectations read straight off the scanner rules; PREDICTED rows use the scanner copy
  dir_row_t dir_tab [25] = '{
    '{8'hFF,     1'b1, 1'b0, 1,         K_NL,     8'h00,     K_TEXT, 8'h00},
    '{8'h00,     1'b0, 1'b0, 1,         K_TEXT,   8'h00,     K_TEXT, 8'h00},
    '{8'hFF,     1'b0, 1'b0, 1,         K_TEXT,   8'hFF,     K_TEXT, 8'h00},
    '{CH_HASH,   1'b0, 1'b0, PREDICTED, K_TEXT,   8'h00,     K_TEXT, 8'h00},
    '{CH_SLASH,  1'b0, 1'b0, 0,         K_TEXT,   8'h00,     K_TEXT, 8'h00},
    '{CH_SLASH,  1'b0, 1'b0, 1,         K_LSTART, 8'h00,     K_TEXT, 8'h00},
    '{CH_STAR,   1'b0, 1'b0, PREDICTED, K_TEXT,   8'h00,     K_TEXT, 8'h00},
    '{8'h00,     1'b1, 1'b0, 1,         K_LEND,   8'h00,     K_TEXT, 8'h00},
    '{CH_SLASH,  1'b0, 1'b0, 0,         K_TEXT,   8'h00,     K_TEXT, 8'h00},
    '{8'h61,     1'b0, 1'b0, 2,         K_TEXT,   CH_SLASH,  K_TEXT, 8'h61},
    '{CH_DQUOTE, 1'b0, 1'b0, PREDICTED, K_TEXT,   8'h00,     K_TEXT, 8'h00},
    '{CH_BSLASH, 1'b0, 1'b0, PREDICTED, K_TEXT,   8'h00,     K_TEXT, 8'h00},
    '{CH_DQUOTE, 1'b0, 1'b0, PREDICTED, K_TEXT,   8'h00,     K_TEXT, 8'h00},
    '{CH_SLASH,  1'b0, 1'b0, PREDICTED, K_TEXT,   8'h00,     K_TEXT, 8'h00},
    '{CH_SLASH,  1'b0, 1'b0, PREDICTED, K_TEXT,   8'h00,     K_TEXT, 8'h00},
    '{CH_DQUOTE, 1'b0, 1'b0, PREDICTED, K_TEXT,   8'h00,     K_TEXT, 8'h00},
    '{CH_SLASH,  1'b0, 1'b0, 0,         K_TEXT,   8'h00,     K_TEXT, 8'h00},
    '{CH_STAR,   1'b0, 1'b0, 1,         K_BSTART, 8'h00,     K_TEXT, 8'h00},
    '{CH_SLASH,  1'b0, 1'b0, PREDICTED, K_TEXT,   8'h00,     K_TEXT, 8'h00},
    '{CH_STAR,   1'b0, 1'b0, 0,         K_TEXT,   8'h00,     K_TEXT, 8'h00},
    '{8'h78,     1'b0, 1'b1, PREDICTED, K_TEXT,   8'h00,     K_TEXT, 8'h00},
    '{CH_SLASH,  1'b0, 1'b0, 0,         K_TEXT,   8'h00,     K_TEXT, 8'h00},
    '{8'h00,     1'b1, 1'b0, 2,         K_TEXT,   CH_SLASH,  K_NL,   8'h00},
    '{CH_SLASH,  1'b0, 1'b0, 0,         K_TEXT,   8'h00,     K_TEXT, 8'h00},
    '{CH_STAR,   1'b0, 1'b0, 1,         K_BSTART, 8'h00,     K_TEXT, 8'h00}
  };

  // Short source fragments that reach delimiters, quotes and escapes
  string frags [10] = '{"/*", "*/", "//", "#", "\"a\\\"/*\"", "'\\\\'//", "/", "*", "\\",
                        "x/y*z"};

  logic [1:0] phase_style [NUM_PHASES] = '{STYLE_HASH, STYLE_NONE, STYLE_NEST, STYLE_SLASH,
                                          STYLE_NEST, STYLE_HASH};

  // Clock
  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Cycle limit
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Receiver stalls
  always @(negedge clk) begin
    tokens_if.ready <= ($urandom_range(99) >= sink_idle_pct);
  end

  function automatic void add_tok(kind_t k, logic [7:0] b);
    tok_t t;
    t.kind      = k;
    t.text_byte = (k == K_TEXT) ? b : 8'h00;
    t.last      = 1'b0;
    step_toks   = {step_toks, t};
  endfunction

  // Byte with nothing held
  function automatic void scan_fresh(logic [7:0] c);
    if (in_line_cmt) begin
      add_tok(K_TEXT, c);
    end else if (nest_level != 0) begin
      if (c == CH_STAR || (style_reg == STYLE_NEST && c == CH_SLASH)) begin
        pend_byte  = c;
        pend_valid = 1'b1;
      end else begin
        add_tok(K_TEXT, c);
      end
    end else if (quote_char != 8'h00) begin
      if (esc_pending) esc_pending = 1'b0;
      else if (c == CH_BSLASH) esc_pending = 1'b1;
      else if (c == quote_char) quote_char = 8'h00;
      add_tok(K_TEXT, c);
    end else if (c == CH_SQUOTE || c == CH_DQUOTE) begin
      quote_char = c;
      add_tok(K_TEXT, c);
    end else if (style_reg == STYLE_HASH && c == CH_HASH) begin
      in_line_cmt = 1'b1;
      add_tok(K_LSTART, 8'h00);
    end else if ((style_reg == STYLE_SLASH || style_reg == STYLE_NEST) && c == CH_SLASH) begin
      pend_byte  = c;
      pend_valid = 1'b1;
    end else begin
      add_tok(K_TEXT, c);
    end
  endfunction

  // Work out the result words of one source word into step_toks
  function automatic void predict_tokens(logic [7:0] c, logic le, logic fs);
    logic [7:0] h;
    logic       paired;
    step_toks.delete();
    if (fs) nest_level = '0;
    if (le) begin
      if (pend_valid) add_tok(K_TEXT, pend_byte);
      add_tok(in_line_cmt ? K_LEND : K_NL, 8'h00);
      pend_valid  = 1'b0;
      pend_byte   = 8'h00;
      quote_char  = 8'h00;
      esc_pending = 1'b0;
      in_line_cmt = 1'b0;
    end else if (pend_valid) begin
      h          = pend_byte;
      pend_valid = 1'b0;
      pend_byte  = 8'h00;
      paired     = 1'b0;
      if (nest_level != 0) begin
        if (style_reg == STYLE_NEST && h == CH_SLASH && c == CH_STAR) begin
          if (nest_level != LEVEL_MAX) nest_level = nest_level + 1'b1;
          add_tok(K_BSTART, 8'h00);
          paired = 1'b1;
        end else if (h == CH_STAR && c == CH_SLASH) begin
          nest_level = nest_level - 1'b1;
          add_tok(K_BEND, 8'h00);
          paired = 1'b1;
        end
      end else if (!in_line_cmt && quote_char == 8'h00 && h == CH_SLASH &&
                   (style_reg == STYLE_SLASH || style_reg == STYLE_NEST)) begin
        if (c == CH_SLASH) begin
          in_line_cmt = 1'b1;
          add_tok(K_LSTART, 8'h00);
          paired = 1'b1;
        end else if (c == CH_STAR) begin
          nest_level = DEPTH_BITS'(1);
          add_tok(K_BSTART, 8'h00);
          paired = 1'b1;
        end
      end
      if (!paired) begin
        add_tok(K_TEXT, h);
        scan_fresh(c);
      end
    end else begin
      scan_fresh(c);
    end
    if (step_toks.size() > 0) step_toks[step_toks.size()-1].last = 1'b1;
  endfunction

  // Offer one source word; called and returns at a falling edge
  task automatic send_word(logic [7:0] c, logic le, logic fs, logic use_typed);
    while ($urandom_range(99) < src_idle_pct) begin
      chars_if.valid <= 1'b0;
      @(negedge clk);
    end
    chars_if.valid      <= 1'b1;
    chars_if.char_byte  <= c;
    chars_if.line_end   <= le;
    chars_if.file_start <= fs;
    do @(posedge clk); while (!chars_if.ready);
    predict_tokens(c, le, fs);
    if (use_typed) begin
      token_q = {token_q, typed_toks};
    end else begin
      token_q = {token_q, step_toks};
    end
    @(negedge clk);
  endtask

  // Hold off the sender until every expected word has come out
  task automatic wait_drained();
    chars_if.valid <= 1'b0;
    while (token_q.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_style(logic [1:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_STYLE, 2'b00};
    pwdata  <= 32'(v);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    style_reg = v;
  endtask

  // Check each word taken from the output against the oldest expectation
  always @(posedge clk) begin
    tok_t want;
    if (!rst && tokens_if.valid && tokens_if.ready) begin
      if (token_q.size() == 0) begin
        $error("unexpected word: kind %0d text_byte %02h last %0b",
               tokens_if.kind, tokens_if.text_byte, tokens_if.last);
        err_cnt++;
      end else begin
        want = token_q.pop_front();
        if (tokens_if.kind !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, tokens_if.kind);
          err_cnt++;
        end
        if (tokens_if.text_byte !== want.text_byte) begin
          $error("text_byte: expected %02h, got %02h", want.text_byte, tokens_if.text_byte);
          err_cnt++;
        end
        if (tokens_if.last !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, tokens_if.last);
          err_cnt++;
        end
      end
    end
  end

  initial begin
    tok_t       t;
    string      s;
    int         pick;
    int         n_items;
    logic       fs;
    rst                 = 1'b1;
    chars_if.valid      = 1'b0;
    chars_if.char_byte  = 8'h00;
    chars_if.line_end   = 1'b0;
    chars_if.file_start = 1'b0;
    tokens_if.ready     = 1'b0;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = 32'h0;
    style_reg           = STYLE_RESET;
    pend_byte           = 8'h00;
    pend_valid          = 1'b0;
    nest_level          = '0;
    quote_char          = 8'h00;
    esc_pending         = 1'b0;
    in_line_cmt         = 1'b0;

    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed table under the reset style; leaves a block open
    foreach (dir_tab[r]) begin
      typed_toks.delete();
      if (dir_tab[r].n_exp >= 1) begin
        t.kind      = dir_tab[r].k0;
        t.text_byte = dir_tab[r].b0;
        t.last      = (dir_tab[r].n_exp == 1);
        typed_toks  = {typed_toks, t};
      end
      if (dir_tab[r].n_exp == 2) begin
        t.kind      = dir_tab[r].k1;
        t.text_byte = dir_tab[r].b1;
        t.last      = 1'b1;
        typed_toks  = {typed_toks, t};
      end
      send_word(dir_tab[r].c, dir_tab[r].le, dir_tab[r].fs, dir_tab[r].n_exp != PREDICTED);
    end

    // Random phases: style changes while idle, idling pattern per pair of phases
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      wait_drained();
      write_style(phase_style[ph]);
      case (ph / 2)
        0: begin
          src_idle_pct  = 25;
          sink_idle_pct = 75;
        end
        1: begin
          src_idle_pct  = 75;
          sink_idle_pct = 25;
        end
        default: begin
          src_idle_pct  = 0;
          sink_idle_pct = 0;
        end
      endcase

      // End the line so no quote or line comment hides the delimiters, then nest past
      // the depth limit, unwind a few levels and end the line
      if (ph == 2) begin
        send_word(8'h00, 1'b1, 1'b0, 1'b0);
        send_word(CH_SLASH, 1'b0, 1'b1, 1'b0);
        send_word(CH_STAR, 1'b0, 1'b0, 1'b0);
        for (int k = 1; k < NEST_OPENS; k++) begin
          send_word(CH_SLASH, 1'b0, 1'b0, 1'b0);
          send_word(CH_STAR, 1'b0, 1'b0, 1'b0);
        end
        for (int k = 0; k < 3; k++) begin
          send_word(CH_STAR, 1'b0, 1'b0, 1'b0);
          send_word(CH_SLASH, 1'b0, 1'b0, 1'b0);
        end
        send_word(8'(($urandom_range(255))), 1'b1, 1'b0, 1'b0);
      end

      n_items = 0;
      while (n_items < PHASE_ITEMS) begin
        pick = $urandom_range(15);
        fs   = ($urandom_range(31) == 0);
        if (pick < 5) begin
          send_word(8'($urandom_range(255)), 1'b0, fs, 1'b0);
          n_items++;
        end else if (pick < 7) begin
          send_word(8'($urandom_range(255)), 1'b1, fs, 1'b0);
          n_items++;
        end else begin
          s = frags[$urandom_range(9)];
          for (int i = 0; i < s.len(); i++) begin
            send_word(s[i], 1'b0, (i == 0) ? fs : 1'b0, 1'b0);
            n_items++;
          end
        end
        if ($urandom_range(99) == 0) wait_drained();
      end
    end

    // Let the last words drain, then report
    wait_drained();
    repeat (TAIL) @(negedge clk);
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
